// ===== rtl/core/apdac_pkg.sv =====
package apdac_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned PwmBitsDefault = 7;
  localparam int unsigned AvgBitsDefault = 0;

  // Queue depths (powers of two, at least 2).
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 4;

  // Warm-up tick counter saturates well above the thresholds it is compared with.
  localparam int unsigned WarmBits    = 3;
  localparam logic [WarmBits-1:0] WarmCtrlMin = 3'd3;
  localparam logic [WarmBits-1:0] WarmAvgMin  = 3'd4;

  // Request codes of the input word.
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // Configuration register indexes.
  localparam logic CfgControlEnable = 1'b0;
  localparam logic CfgSetpoint      = 1'b1;

  // Reset values and the sample offset.
  localparam logic [15:0] SetpointReset = 16'd9930;
  localparam logic [15:0] DriveReset    = 16'd50;
  localparam logic [15:0] SampleOffset  = 16'h8000;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] uart_byte;
    logic       drive_update;
    logic [7:0] r2r_out;
    logic [6:0] pwm_out;
    logic       sweep_done;
    logic       last;
  } res_t;

  typedef enum logic {
    CMD_CTRL = 1'b0,
    CMD_AVG  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] sample;
  } cmd_t;

endpackage

// ===== rtl/core/adc_pi_loop_and_dac_sweep.sv =====
// PI control loop and DAC calibration sweep fed by converter bytes.
// Input channel: push/full. Each word is a timer tick or one converter byte;
// two bytes (high first) form a sample. A word is taken on a clock edge with
// push high and full low. Ticks and high bytes only update front-end registers.
// Result channel: empty/pop. The oldest result word sits on res_o while empty
// is low and leaves on an edge with pop high. A control sample yields two
// words, a completed average yields four, and last marks the final word.
// A sample goes through the command queue, burst registers and result queue.
// The back end emits one word per cycle while the result queue has room, and
// takes the next command as a burst's last word goes out. With a two-entry
// command queue and a four-entry result queue, input flows while the output
// stalls until both queues fill; full then rises until pop drains them.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Index 0 selects control mode, index 1 the setpoint.
// Reset sets the control state but not queue storage or burst bytes: drive
// starts at 50, setpoint at 9930, control mode enabled, both queues empty.
module adc_pi_loop_and_dac_sweep #(
  parameter int unsigned PWM_BITS = apdac_pkg::PwmBitsDefault,
  parameter int unsigned AVG_BITS = apdac_pkg::AvgBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  apdac_pkg::item_t item_i,
  output logic             empty,
  input  logic             pop,
  output apdac_pkg::res_t  res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  logic        control_enable_q, control_enable_d;
  logic [15:0] setpoint_q, setpoint_d;

  logic            cmd_push;
  apdac_pkg::cmd_t cmd_wr;
  apdac_pkg::cmd_t cmd_rd;
  logic            cmd_full;
  logic            cmd_empty;
  logic            cmd_pop;

  logic            res_push;
  apdac_pkg::res_t res_wr;
  logic            res_full;

  // Config registers; the user writes only while the block is idle, unchecked.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    control_enable_d = control_enable_q;
    setpoint_d       = setpoint_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        apdac_pkg::CfgControlEnable: control_enable_d = cfg_data_i[0];
        apdac_pkg::CfgSetpoint:      setpoint_d       = cfg_data_i;
        default:                     control_enable_d = control_enable_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_enable_q <= 1'b1;
      setpoint_q       <= apdac_pkg::SetpointReset;
    end else begin
      control_enable_q <= control_enable_d;
      setpoint_q       <= setpoint_d;
    end
  end

  // Front end: byte pairing, warm-up count and mode selection.
  apdac_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .item_i           (item_i),
    .full_o           (full),
    .control_enable_i (control_enable_q),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_wr),
    .cmd_full_i       (cmd_full)
  );

  // Command queue between the two halves.
  apdac_fifo #(
    .WIDTH ($bits(apdac_pkg::cmd_t)),
    .DEPTH (apdac_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd),
    .empty_o (cmd_empty)
  );

  // Back end: PI step or averaging sweep, then the word burst.
  apdac_back #(
    .PWM_BITS (PWM_BITS),
    .AVG_BITS (AVG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .setpoint_i  (setpoint_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (res_full),
    .out_push_o  (res_push),
    .out_o       (res_wr)
  );

  // Result queue that decouples the back end from the receiver.
  apdac_fifo #(
    .WIDTH ($bits(apdac_pkg::res_t)),
    .DEPTH (apdac_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wr),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

// ===== rtl/core/apdac_fifo.sv =====
module apdac_fifo #(
  parameter int unsigned WIDTH = $bits(apdac_pkg::res_t),
  parameter int unsigned DEPTH = apdac_pkg::ResDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wr_q, wr_d;
  logic [AW:0]      rd_q, rd_d;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
  assign rdata_o = mem_q[rd_q[AW-1:0]];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_i && !full_o) begin
      wr_d = wr_q + (AW+1)'(1);
    end
    if (pop_i && !empty_o) begin
      rd_d = rd_q + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/apdac_front.sv =====
module apdac_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  apdac_pkg::item_t    item_i,
  output logic                full_o,
  input  logic                control_enable_i,
  output logic                cmd_push_o,
  output apdac_pkg::cmd_t     cmd_o,
  input  logic                cmd_full_i
);

  logic                             phase_q, phase_d;
  logic [7:0]                       high_q, high_d;
  logic [apdac_pkg::WarmBits-1:0]   warm_q, warm_d;
  logic                             accept;
  logic                             is_ctrl;
  logic                             is_avg;

  assign full_o = cmd_full_i;
  assign accept = push_i && !cmd_full_i;

  assign is_ctrl = control_enable_i && (warm_q > apdac_pkg::WarmCtrlMin);
  assign is_avg  = !is_ctrl && (warm_q > apdac_pkg::WarmAvgMin);

  assign cmd_o.sample = {high_q, item_i.rx_byte} ^ apdac_pkg::SampleOffset;
  assign cmd_o.kind   = is_ctrl ? apdac_pkg::CMD_CTRL : apdac_pkg::CMD_AVG;

  // A low byte completes a sample; it only goes on if one of the modes wants it.
  assign cmd_push_o = accept && (item_i.req_type == apdac_pkg::ReqByte) && phase_q
                      && (is_ctrl || is_avg);

  always_comb begin
    phase_d = phase_q;
    high_d  = high_q;
    warm_d  = warm_q;
    if (accept) begin
      if (item_i.req_type == apdac_pkg::ReqTick) begin
        if (warm_q != '1) begin
          warm_d = warm_q + apdac_pkg::WarmBits'(1);
        end
      end else if (!phase_q) begin
        high_d  = item_i.rx_byte;
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      high_q  <= '0;
      warm_q  <= '0;
    end else begin
      phase_q <= phase_d;
      high_q  <= high_d;
      warm_q  <= warm_d;
    end
  end

endmodule

// ===== rtl/core/apdac_back.sv =====
module apdac_back #(
  parameter int unsigned PWM_BITS = apdac_pkg::PwmBitsDefault,
  parameter int unsigned AVG_BITS = apdac_pkg::AvgBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      setpoint_i,
  input  logic             cmd_valid_i,
  input  apdac_pkg::cmd_t  cmd_i,
  output logic             cmd_pop_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output apdac_pkg::res_t  out_o
);

  localparam int unsigned SumW = 16 + AVG_BITS;
  localparam logic [AVG_BITS:0] AvgFull  = (AVG_BITS+1)'(1 << AVG_BITS);
  localparam logic [15:0]       PwmMask  = 16'((1 << PWM_BITS) - 1);

  // Loop and sweep state.
  logic [15:0]            integral_q, integral_d;
  logic [15:0]            drive_q, drive_d;
  logic [AVG_BITS:0]      count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [15:0]            frame_q, frame_d;
  logic [PWM_BITS-1:0]    duty_q, duty_d;
  logic [15:0]            step_q, step_d;

  // Burst of words for the current sample.
  logic [7:0] bytes_q [4];
  logic [7:0] bytes_d [4];
  logic [7:0] r2r_q, r2r_d;
  logic [6:0] pwm_q, pwm_d;
  logic       done_q, done_d;
  logic [2:0] left_q, left_d;
  logic [1:0] idx_q, idx_d;

  logic                   emit;
  logic [15:0]            err;
  logic [15:0]            integ_n;
  logic [15:0]            drive_n;
  logic [15:0]            drive_sh;
  logic [15:0]            drive_pm;
  logic signed [SumW-1:0] s_ext;
  logic signed [SumW-1:0] sum_n;
  logic signed [SumW-1:0] mean_w;
  logic [AVG_BITS:0]      count_n;
  logic                   avg_full;
  logic [PWM_BITS-1:0]    duty_n;
  logic [15:0]            step_n;
  logic [15:0]            duty16;

  assign emit       = (left_q != 3'd0) && !out_full_i;
  assign out_push_o = emit;
  assign cmd_pop_o  = cmd_valid_i && ((left_q == 3'd0) || ((left_q == 3'd1) && emit));

  assign out_o.uart_byte    = bytes_q[idx_q];
  assign out_o.last         = (left_q == 3'd1);
  assign out_o.drive_update = (left_q == 3'd1);
  assign out_o.r2r_out      = (left_q == 3'd1) ? r2r_q : 8'd0;
  assign out_o.pwm_out      = (left_q == 3'd1) ? pwm_q : 7'd0;
  assign out_o.sweep_done   = done_q;

  // PI step, 16-bit wrapping, arithmetic P and I shifts.
  assign err      = setpoint_i - cmd_i.sample;
  assign integ_n  = integral_q + err;
  assign drive_n  = drive_q + 16'($signed(err) >>> 1) + 16'($signed(integ_n) >>> 3);
  assign drive_sh = drive_n >> PWM_BITS;
  assign drive_pm = drive_n & PwmMask;

  // Averaging and sweep advance.
  assign s_ext    = SumW'($signed(cmd_i.sample));
  assign sum_n    = sum_q + s_ext;
  assign mean_w   = sum_n >>> AVG_BITS;
  assign count_n  = count_q + (AVG_BITS+1)'(1);
  assign avg_full = (count_n == AvgFull);
  assign duty_n   = duty_q + PWM_BITS'(1);
  assign step_n   = (duty_q == '1) ? step_q + 16'd1 : step_q;
  assign duty16   = 16'(duty_n);

  always_comb begin
    integral_d = integral_q;
    drive_d    = drive_q;
    count_d    = count_q;
    sum_d      = sum_q;
    frame_d    = frame_q;
    duty_d     = duty_q;
    step_d     = step_q;
    bytes_d    = bytes_q;
    r2r_d      = r2r_q;
    pwm_d      = pwm_q;
    done_d     = done_q;
    left_d     = left_q;
    idx_d      = idx_q;

    if (emit) begin
      left_d = left_q - 3'd1;
      idx_d  = idx_q + 2'd1;
    end

    if (cmd_pop_o) begin
      idx_d = 2'd0;
      unique case (cmd_i.kind)
        apdac_pkg::CMD_CTRL: begin
          integral_d = integ_n;
          drive_d    = drive_n;
          bytes_d[0] = cmd_i.sample[15:8];
          bytes_d[1] = cmd_i.sample[7:0];
          r2r_d      = drive_sh[7:0];
          pwm_d      = drive_pm[6:0];
          done_d     = |step_q[15:8];
          left_d     = 3'd2;
        end
        apdac_pkg::CMD_AVG: begin
          if (avg_full) begin
            count_d    = '0;
            sum_d      = '0;
            frame_d    = frame_q + 16'd1;
            duty_d     = duty_n;
            step_d     = step_n;
            bytes_d[0] = frame_q[15:8];
            bytes_d[1] = frame_q[7:0];
            bytes_d[2] = mean_w[15:8];
            bytes_d[3] = mean_w[7:0];
            r2r_d      = step_n[7:0];
            pwm_d      = duty16[6:0];
            done_d     = |step_n[15:8];
            left_d     = 3'd4;
          end else begin
            count_d = count_n;
            sum_d   = sum_n;
            left_d  = 3'd0;
          end
        end
        default: begin
          left_d = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      drive_q    <= apdac_pkg::DriveReset;
      count_q    <= '0;
      sum_q      <= '0;
      frame_q    <= '0;
      duty_q     <= '0;
      step_q     <= '0;
      done_q     <= 1'b0;
      left_q     <= '0;
      idx_q      <= '0;
    end else begin
      integral_q <= integral_d;
      drive_q    <= drive_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      frame_q    <= frame_d;
      duty_q     <= duty_d;
      step_q     <= step_d;
      done_q     <= done_d;
      left_q     <= left_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    r2r_q   <= r2r_d;
    pwm_q   <= pwm_d;
  end

endmodule
